/* design/rae_pkg.sv */
// ----------------------------------------------------------------------------
// rae_pkg: shared types and constants for the register ALU execute block
// Opcodes, status codes, ALU operation codes, the sequencer states and the
// control structs passed between the sequencer and the shared ALU.
// ----------------------------------------------------------------------------
package rae_pkg;

	localparam int DATA_W    = 64;
	localparam int BYTE_W    = 8;
	localparam int REG_COUNT = 32;
	localparam int IDX_W     = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
	localparam int CNT_W     = $clog2(DATA_W);
	localparam int STAT_W    = 2;

	// Packed stream widths, padded to whole bytes
	localparam int IN_RAW_W  = 3 * BYTE_W + DATA_W;
	localparam int IN_W      = ((IN_RAW_W + BYTE_W - 1) / BYTE_W) * BYTE_W;
	localparam int OUT_RAW_W = STAT_W + DATA_W;
	localparam int OUT_W     = ((OUT_RAW_W + BYTE_W - 1) / BYTE_W) * BYTE_W;

	localparam logic [BYTE_W-1:0] OP_NOP  = 8'h00;
	localparam logic [BYTE_W-1:0] OP_LOAD = 8'h01;
	localparam logic [BYTE_W-1:0] OP_MOVE = 8'h02;
	localparam logic [BYTE_W-1:0] OP_ADD  = 8'h03;
	localparam logic [BYTE_W-1:0] OP_SUB  = 8'h04;
	localparam logic [BYTE_W-1:0] OP_MUL  = 8'h05;
	localparam logic [BYTE_W-1:0] OP_DIV  = 8'h06;
	localparam logic [BYTE_W-1:0] OP_MOD  = 8'h07;
	localparam logic [BYTE_W-1:0] OP_NOP2 = 8'h08;

	localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STAT_BAD_REG  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_BAD_INSN = 2'd2;
	localparam logic [STAT_W-1:0] STAT_DIV_ZERO = 2'd3;

	typedef enum logic [2:0] {
		ALU_MOVE,
		ALU_ADD,
		ALU_SUB,
		ALU_MUL,
		ALU_DIV,
		ALU_MOD
	} alu_op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_EXEC,
		S_ALU,
		S_DONE
	} seq_state_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	typedef struct packed {
		logic done;
	} alu_rsp_t;

	function automatic logic reg_ok(input logic [BYTE_W-1:0] idx);
		return {1'b0, idx} < (BYTE_W + 1)'(REG_COUNT);
	endfunction

endpackage

/* design/rae_regfile.sv */
// ----------------------------------------------------------------------------
// rae_regfile: register file of the execute block
// One write port, two registered read ports. A valid bit per entry stands in
// for clearing at reset: an entry never written since reset reads as zero.
// ----------------------------------------------------------------------------
module rae_regfile import rae_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [IDX_W-1:0]  rd_addr_a,
	input  logic [IDX_W-1:0]  rd_addr_b,
	output logic [DATA_W-1:0] rd_data_a,
	output logic [DATA_W-1:0] rd_data_b,
	input  logic              wr_en,
	input  logic [IDX_W-1:0]  wr_addr,
	input  logic [DATA_W-1:0] wr_data
);

	logic [DATA_W-1:0]    mem [REG_COUNT];
	logic [REG_COUNT-1:0] vld_q;
	logic [DATA_W-1:0]    rda_q;
	logic [DATA_W-1:0]    rdb_q;
	logic                 rda_vld_q;
	logic                 rdb_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rda_q <= mem[rd_addr_a];
		rdb_q <= mem[rd_addr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rda_vld_q <= 1'b0;
			rdb_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			rda_vld_q <= vld_q[rd_addr_a];
			rdb_vld_q <= vld_q[rd_addr_b];
		end
	end

	assign rd_data_a = rda_vld_q ? rda_q : '0;
	assign rd_data_b = rdb_vld_q ? rdb_q : '0;

endmodule

/* design/rae_alu.sv */
// ----------------------------------------------------------------------------
// rae_alu: shared iterative arithmetic unit
// One 65-bit adder/subtractor serves move, add and subtract in a single step,
// shift-add multiply and restoring divide in one bit per step.
// ----------------------------------------------------------------------------
module rae_alu import rae_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  alu_req_t          req,
	input  logic [DATA_W-1:0] opnd_a,
	input  logic [DATA_W-1:0] opnd_b,
	output alu_rsp_t          rsp,
	output logic [DATA_W-1:0] result
);

	alu_op_t             op_q;
	logic                busy_q;
	logic                done_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [DATA_W-1:0]   acc_q;   // accumulator / partial remainder
	logic [DATA_W-1:0]   opa_q;   // multiplicand / dividend-quotient shift
	logic [DATA_W-1:0]   opb_q;   // multiplier / divisor

	logic [DATA_W:0]     add_x;
	logic [DATA_W-1:0]   add_y;
	logic                add_sub;
	logic [DATA_W+1:0]   add_sum;
	logic                add_ge;
	logic                iter_op;
	logic                last;

	always_comb begin
		add_x   = {1'b0, acc_q};
		add_y   = opb_q;
		add_sub = 1'b0;
		iter_op = 1'b0;
		case (op_q)
			ALU_SUB: begin
				add_sub = 1'b1;
			end
			ALU_MUL: begin
				add_y   = opb_q[0] ? opa_q : '0;
				iter_op = 1'b1;
			end
			ALU_DIV, ALU_MOD: begin
				add_x   = {acc_q, opa_q[DATA_W-1]};
				add_sub = 1'b1;
				iter_op = 1'b1;
			end
			default: begin
			end
		endcase
		add_sum = {1'b0, add_x}
			+ {1'b0, (add_sub ? ~{1'b0, add_y} : {1'b0, add_y})}
			+ (DATA_W + 2)'(add_sub);
		add_ge  = add_sum[DATA_W+1];
		last    = !iter_op || (cnt_q == '0);
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= (req.op == ALU_ADD || req.op == ALU_SUB) ? opnd_a : '0;
			opa_q <= opnd_a;
			opb_q <= opnd_b;
			cnt_q <= CNT_W'(DATA_W - 1);
			op_q  <= req.op;
		end else if (busy_q) begin
			case (op_q)
				ALU_MUL: begin
					acc_q <= add_sum[DATA_W-1:0];
					opa_q <= {opa_q[DATA_W-2:0], 1'b0};
					opb_q <= {1'b0, opb_q[DATA_W-1:1]};
				end
				ALU_DIV, ALU_MOD: begin
					acc_q <= add_ge ? add_sum[DATA_W-1:0] : add_x[DATA_W-1:0];
					opa_q <= {opa_q[DATA_W-2:0], add_ge};
				end
				default: begin
					acc_q <= add_sum[DATA_W-1:0];
				end
			endcase
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && last;
			if (req.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && last) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign rsp.done = done_q;
	assign result   = (op_q == ALU_DIV) ? opa_q : acc_q;

endmodule

/* design/register_alu_instruction_execute.sv */
// ----------------------------------------------------------------------------
// register_alu_instruction_execute: register machine instruction execute
// Runs one decoded instruction (nop, load, move, add, sub, mul, div, mod)
// against a file of 32 unsigned 64-bit registers and returns one status and
// written value per instruction.
//
//   channel   dir   fields (lowest bit first)
//   s_axis    in    tdata: action[7:0] dest_reg[15:8] src_reg[23:16]
//                          immediate[87:24]
//   m_axis    out   tdata: status[1:0] written_value[65:2], zero pad to 72
//
// Nop, load and every error finish in the execute state without the shared
// unit; move, add and sub go through the shared adder in rae_alu; mul, div
// and mod take its 64 one-bit steps.
// Reset clears all control state and the register valid bits at once; no
// clearing pass is needed, so the block is ready the cycle after reset.
// A result waiting on m_axis does not block the next input transfer; a
// second result waits in the final sequencer state until the first is taken.
// ----------------------------------------------------------------------------
module register_alu_instruction_execute import rae_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [IN_W-1:0]  s_axis_tdata,   // action, dest_reg, src_reg, immediate
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [OUT_W-1:0] m_axis_tdata    // status, written_value, pad
);

	seq_state_t          state_q;
	seq_state_t          state_nxt;

	// Instruction held for the whole run
	logic [BYTE_W-1:0]   act_q;
	logic [BYTE_W-1:0]   dst_q;
	logic [BYTE_W-1:0]   src_q;
	logic [DATA_W-1:0]   imm_q;

	// Result staged before the register write and output load
	logic [STAT_W-1:0]   res_stat_q;
	logic [DATA_W-1:0]   res_val_q;
	logic                res_we_q;
	logic                res_load;
	logic [STAT_W-1:0]   res_stat_nxt;
	logic [DATA_W-1:0]   res_val_nxt;
	logic                res_we_nxt;

	// Output register
	logic                out_vld_q;
	logic [STAT_W-1:0]   out_stat_q;
	logic [DATA_W-1:0]   out_val_q;
	logic                out_load;

	logic                in_xfer;
	logic [DATA_W-1:0]   rd_a;
	logic [DATA_W-1:0]   rd_b;
	logic                rf_we;
	alu_req_t            alu_req;
	alu_rsp_t            alu_rsp;
	logic [DATA_W-1:0]   alu_result;

	assign in_xfer = s_axis_tvalid && s_axis_tready;

	// Capture the instruction on its input transfer
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			act_q <= s_axis_tdata[BYTE_W-1:0];
			dst_q <= s_axis_tdata[2*BYTE_W-1:BYTE_W];
			src_q <= s_axis_tdata[3*BYTE_W-1:2*BYTE_W];
			imm_q <= s_axis_tdata[3*BYTE_W+DATA_W-1:3*BYTE_W];
		end
	end

	rae_regfile u_regfile (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_addr_a (dst_q[IDX_W-1:0]),
		.rd_addr_b (src_q[IDX_W-1:0]),
		.rd_data_a (rd_a),
		.rd_data_b (rd_b),
		.wr_en     (rf_we),
		.wr_addr   (dst_q[IDX_W-1:0]),
		.wr_data   (res_val_q)
	);

	rae_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.opnd_a (rd_a),
		.opnd_b (rd_b),
		.rsp    (alu_rsp),
		.result (alu_result)
	);

	// Sequencer: next state, decode and result staging
	always_comb begin
		state_nxt     = state_q;
		s_axis_tready = 1'b0;
		alu_req.start = 1'b0;
		alu_req.op    = ALU_MOVE;
		res_load      = 1'b0;
		res_stat_nxt  = STAT_OK;
		res_val_nxt   = '0;
		res_we_nxt    = 1'b0;
		out_load      = 1'b0;
		rf_we         = 1'b0;

		case (act_q)
			OP_ADD:  alu_req.op = ALU_ADD;
			OP_SUB:  alu_req.op = ALU_SUB;
			OP_MUL:  alu_req.op = ALU_MUL;
			OP_DIV:  alu_req.op = ALU_DIV;
			OP_MOD:  alu_req.op = ALU_MOD;
			default: alu_req.op = ALU_MOVE;
		endcase

		case (state_q)
			S_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_nxt = S_READ;
				end
			end
			S_READ: begin
				// Register file read lands at the end of this cycle
				state_nxt = S_EXEC;
			end
			S_EXEC: begin
				res_load  = 1'b1;
				state_nxt = S_DONE;
				if (act_q == OP_NOP || act_q == OP_NOP2) begin
					res_stat_nxt = STAT_OK;
				end else if (act_q > OP_NOP2) begin
					res_stat_nxt = STAT_BAD_INSN;
				end else if (act_q == OP_LOAD) begin
					if (reg_ok(dst_q)) begin
						res_val_nxt = imm_q;
						res_we_nxt  = 1'b1;
					end else begin
						res_stat_nxt = STAT_BAD_REG;
					end
				end else if (!reg_ok(dst_q) || !reg_ok(src_q)) begin
					res_stat_nxt = STAT_BAD_REG;
				end else if ((act_q == OP_DIV || act_q == OP_MOD) && rd_b == '0) begin
					res_stat_nxt = STAT_DIV_ZERO;
				end else begin
					// Hand the operands to the shared unit
					res_load      = 1'b0;
					alu_req.start = 1'b1;
					state_nxt     = S_ALU;
				end
			end
			S_ALU: begin
				if (alu_rsp.done) begin
					res_load    = 1'b1;
					res_val_nxt = alu_result;
					res_we_nxt  = 1'b1;
					state_nxt   = S_DONE;
				end
			end
			S_DONE: begin
				// Hold until the output register is free, then commit
				if (!out_vld_q || m_axis_tready) begin
					out_load  = 1'b1;
					rf_we     = res_we_q;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			res_we_q  <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (res_load) begin
				res_we_q <= res_we_nxt;
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_stat_q <= res_stat_nxt;
			res_val_q  <= res_val_nxt;
		end
		if (out_load) begin
			out_stat_q <= res_stat_q;
			out_val_q  <= res_val_q;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {(OUT_W - OUT_RAW_W)'(0), out_val_q, out_stat_q};

`ifndef SYNTHESIS
	// The shared unit reports completion only while the sequencer waits on it
	assert property (@(posedge clk) disable iff (!arst_n)
		alu_rsp.done |-> state_q == S_ALU)
		else $error("ALU done outside ALU wait");

	// A started operation is always followed by the ALU wait state
	assert property (@(posedge clk) disable iff (!arst_n)
		alu_req.start |=> state_q == S_ALU)
		else $error("ALU start not followed by wait");

	// A register write only ever comes with a successful result
	assert property (@(posedge clk) disable iff (!arst_n)
		rf_we |-> res_stat_q == STAT_OK)
		else $error("register write with error status");

	// Any error result carries a zero written value
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && out_stat_q != STAT_OK) |-> out_val_q == '0)
		else $error("error result with nonzero value");

	// Input is taken only when no instruction is in flight
	assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> state_q == S_READ)
		else $error("input transfer did not start a run");
`endif

endmodule

/* test/register_alu_instruction_execute_tb.sv */
// ----------------------------------------------------------------------------
// register_alu_instruction_execute_tb: self-checking bench for the execute block
// Streams decoded instructions into s_axis and checks every status and written
// value on m_axis against a shadow register file kept in the bench. A short
// directed run covers the opcode and index extremes and each error path.
// A long random run follows, mostly well-formed register traffic with some
// bad opcodes and indices mixed in. Both sides idle at random, except for a
// calm window. The receiver also holds off once for a long stretch, so the
// block backs up and stalls its input.
// ----------------------------------------------------------------------------
module register_alu_instruction_execute_tb;
	import rae_pkg::*;

	localparam int RANDOM_ITEMS = 1900;
	localparam int IDLE_PCT     = 22;
	localparam int HOLD_AT      = 300;   // input transfers before the long hold-off
	localparam int HOLD_CYCLES  = 400;
	localparam int CALM_FROM    = 800;   // input transfers bounding the no-idle window
	localparam int CALM_TO      = 1100;
	localparam int DRAIN_CYCLES = 120;   // longer than the slowest instruction
	localparam int QUIET_LIMIT  = 4000;  // cycles with no transfer at all

	// One instruction as it sits on s_axis_tdata, lowest field last
	typedef struct packed {
		logic [DATA_W-1:0] immediate;
		logic [BYTE_W-1:0] src_reg;
		logic [BYTE_W-1:0] dest_reg;
		logic [BYTE_W-1:0] action;
	} instr_t;

	// One result as it sits on m_axis_tdata
	typedef struct packed {
		logic [OUT_W-OUT_RAW_W-1:0] pad;
		logic [DATA_W-1:0]          written_value;
		logic [STAT_W-1:0]          status;
	} result_t;

	logic             clk;
	logic             arst_n        = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata  = '0;   // action, dest_reg, src_reg, immediate
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;         // status, written_value, pad

	instr_t            pending_instrs[$];
	result_t           expected_results[$];
	logic [DATA_W-1:0] shadow_regs[REG_COUNT];

	int  instrs_taken   = 0;
	int  mismatch_count = 0;
	int  hold_left      = 0;
	bit  hold_done      = 1'b0;
	int  quiet_cycles   = 0;
	bit  calm;

	register_alu_instruction_execute dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// No idling on either side while this window of transfers goes through
	assign calm = (instrs_taken >= CALM_FROM) && (instrs_taken < CALM_TO);

	task automatic flag_mismatch(input string what, input logic [DATA_W-1:0] got,
			input logic [DATA_W-1:0] want);
		mismatch_count++;
		$display("mismatch on %s: got 0x%h, want 0x%h", what, got, want);
	endtask

	// Run one instruction on the shadow register file and return its result.
	// Two-register operations read both operands before the write, so a
	// register used as both destination and source sees its old value twice.
	function automatic result_t execute_instruction(input instr_t ins);
		result_t           res;
		logic [DATA_W-1:0] lhs;
		logic [DATA_W-1:0] rhs;
		res        = '0;
		res.status = STAT_OK;
		case (ins.action)
		OP_NOP, OP_NOP2: begin
			// leave everything alone, operands ignored
		end
		OP_LOAD: begin
			if (ins.dest_reg < REG_COUNT) begin
				shadow_regs[ins.dest_reg] = ins.immediate;
				res.written_value         = ins.immediate;
			end else begin
				res.status = STAT_BAD_REG;
			end
		end
		OP_MOVE, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
			// the index check wins over the divide-by-zero check
			if (ins.dest_reg >= REG_COUNT || ins.src_reg >= REG_COUNT) begin
				res.status = STAT_BAD_REG;
			end else begin
				lhs = shadow_regs[ins.dest_reg];
				rhs = shadow_regs[ins.src_reg];
				if ((ins.action == OP_DIV || ins.action == OP_MOD) && rhs == '0) begin
					res.status = STAT_DIV_ZERO;
				end else begin
					case (ins.action)
					OP_MOVE: res.written_value = rhs;
					OP_ADD:  res.written_value = lhs + rhs;
					OP_SUB:  res.written_value = lhs - rhs;
					OP_MUL:  res.written_value = lhs * rhs;
					OP_DIV:  res.written_value = lhs / rhs;
					default: res.written_value = lhs % rhs;
					endcase
					shadow_regs[ins.dest_reg] = res.written_value;
				end
			end
		end
		default: res.status = STAT_BAD_INSN;
		endcase
		return res;
	endfunction

	function automatic instr_t make_instr(input logic [BYTE_W-1:0] action,
			input logic [BYTE_W-1:0] dest, input logic [BYTE_W-1:0] src,
			input logic [DATA_W-1:0] imm);
		instr_t ins;
		ins.action    = action;
		ins.dest_reg  = dest;
		ins.src_reg   = src;
		ins.immediate = imm;
		return ins;
	endfunction

	// Values with a fair share of zeros, all-ones, small numbers and single bits
	function automatic logic [DATA_W-1:0] random_word();
		int pick;
		pick = $urandom_range(99);
		if (pick < 8)
			return '0;
		else if (pick < 14)
			return '1;
		else if (pick < 34)
			return DATA_W'($urandom_range(1, 20));
		else if (pick < 44)
			return DATA_W'(1) << $urandom_range(DATA_W - 1);
		else
			return {$urandom, $urandom};
	endfunction

	function automatic logic [BYTE_W-1:0] random_bad_index();
		return BYTE_W'($urandom_range(REG_COUNT, 255));
	endfunction

	// Mostly well-formed register traffic; the rest nops, bad opcodes and
	// out-of-range indices. Operands that an opcode ignores still toggle.
	function automatic instr_t random_instruction();
		instr_t ins;
		int     pick;
		ins.immediate = random_word();
		ins.dest_reg  = BYTE_W'($urandom_range(REG_COUNT - 1));
		ins.src_reg   = BYTE_W'($urandom_range(REG_COUNT - 1));
		pick          = $urandom_range(99);
		if (pick < 6) begin
			ins.action   = BYTE_W'($urandom_range(OP_NOP2 + 1, 255));
			ins.dest_reg = BYTE_W'($urandom_range(255));
			ins.src_reg  = BYTE_W'($urandom_range(255));
		end else if (pick < 10) begin
			ins.action   = $urandom_range(1) ? OP_NOP : OP_NOP2;
			ins.dest_reg = BYTE_W'($urandom_range(255));
			ins.src_reg  = BYTE_W'($urandom_range(255));
		end else if (pick < 36) begin
			ins.action = OP_LOAD;
			if ($urandom_range(99) < 8)
				ins.dest_reg = random_bad_index();
		end else begin
			ins.action = BYTE_W'($urandom_range(OP_MOVE, OP_MOD));
			pick       = $urandom_range(99);
			if (pick < 4)
				ins.dest_reg = random_bad_index();
			else if (pick < 8)
				ins.src_reg = random_bad_index();
			else if (pick < 14)
				ins.src_reg = ins.dest_reg;
		end
		return ins;
	endfunction

	// Sender: predict each accepted instruction, then offer the next pending
	// one unless this cycle idles. Hold the offer steady until it is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_results.push_back(execute_instruction(instr_t'(s_axis_tdata)));
				instrs_taken <= instrs_taken + 1;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_instrs.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
					s_axis_tdata  <= pending_instrs.pop_front();
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: check each result transfer against the oldest prediction and
	// decide tready for the next cycle. Once, drop tready for a long stretch
	// while the sender keeps offering, so the block fills and stalls s_axis.
	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = result_t'(m_axis_tdata);
				if (expected_results.size() == 0) begin
					flag_mismatch("unexpected result", got.written_value, '0);
				end else begin
					want = expected_results.pop_front();
					if (got.status !== want.status)
						flag_mismatch("status", DATA_W'(got.status), DATA_W'(want.status));
					if (got.written_value !== want.written_value)
						flag_mismatch("written_value", got.written_value, want.written_value);
				end
			end
			if (hold_left != 0) begin
				hold_left     <= hold_left - 1;
				m_axis_tready <= 1'b0;
			end else if (!hold_done && instrs_taken >= HOLD_AT) begin
				hold_left     <= HOLD_CYCLES;
				hold_done     <= 1'b1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// Watchdog: give up when nothing moves on either side for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
				$display("[register_alu_instruction_execute] ERROR");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		// register file starts cleared, as after reset
		foreach (shadow_regs[i])
			shadow_regs[i] = '0;

		// Directed: nops with wild operands, unknown opcodes, load extremes
		pending_instrs.push_back(make_instr(OP_NOP, 8'hff, 8'hff, '1));
		pending_instrs.push_back(make_instr(OP_NOP2, 8'd40, 8'd200, 64'h0123_4567_89ab_cdef));
		pending_instrs.push_back(make_instr(OP_NOP2 + 8'd1, 8'd0, 8'd0, '0));
		pending_instrs.push_back(make_instr(8'hff, 8'hff, 8'hff, '1));
		pending_instrs.push_back(make_instr(OP_LOAD, 8'd32, 8'd0, 64'd5));
		pending_instrs.push_back(make_instr(OP_LOAD, 8'hff, 8'd0, '1));
		pending_instrs.push_back(make_instr(OP_LOAD, 8'd0, 8'hff, '1));
		pending_instrs.push_back(make_instr(OP_LOAD, 8'd31, 8'd0, 64'h8000_0000_0000_0001));
		pending_instrs.push_back(make_instr(OP_LOAD, 8'd1, 8'd0, 64'd3));
		// add wraps: all-ones + 3
		pending_instrs.push_back(make_instr(OP_ADD, 8'd0, 8'd1, '0));
		// sub wraps below zero: 0 - 3
		pending_instrs.push_back(make_instr(OP_SUB, 8'd2, 8'd1, '0));
		// same register as both operands; multiply keeps the low half
		pending_instrs.push_back(make_instr(OP_MUL, 8'd31, 8'd31, '0));
		pending_instrs.push_back(make_instr(OP_MOVE, 8'd3, 8'd2, '0));
		pending_instrs.push_back(make_instr(OP_DIV, 8'd3, 8'd1, '0));
		// divide and modulo by a zero register
		pending_instrs.push_back(make_instr(OP_DIV, 8'd3, 8'd4, '0));
		pending_instrs.push_back(make_instr(OP_MOD, 8'd3, 8'd4, '0));
		pending_instrs.push_back(make_instr(OP_MOD, 8'd2, 8'd0, '0));
		// bad index beats divide by zero
		pending_instrs.push_back(make_instr(OP_DIV, 8'd32, 8'd4, '0));
		pending_instrs.push_back(make_instr(OP_ADD, 8'd5, 8'd200, '0));
		pending_instrs.push_back(make_instr(OP_MUL, 8'hff, 8'd0, '0));
		pending_instrs.push_back(make_instr(OP_ADD, 8'd2, 8'd2, '0));
		pending_instrs.push_back(make_instr(OP_LOAD, 8'd4, 8'd0, 64'd7));
		pending_instrs.push_back(make_instr(OP_DIV, 8'd2, 8'd4, '0));
		pending_instrs.push_back(make_instr(OP_MOD, 8'd0, 8'd4, '0));

		repeat (RANDOM_ITEMS)
			pending_instrs.push_back(random_instruction());

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// drain: every instruction taken and every result seen
		while (pending_instrs.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
			@(posedge clk);
		// let any stray result surface before judging
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("[register_alu_instruction_execute] OK");
		else
			$display("[register_alu_instruction_execute] ERROR");
		$finish;
	end

endmodule

/* files.f */
design/rae_pkg.sv
design/rae_regfile.sv
design/rae_alu.sv
design/register_alu_instruction_execute.sv
test/register_alu_instruction_execute_tb.sv
